@@ hw/rtl/mmtrs_pkg.sv @@
`default_nettype none
package mmtrs_pkg;

    localparam int unsigned CordicIterDefault = 16;
    localparam int unsigned CordicIterMax     = 24;

    localparam int unsigned ScaleW = 24;
    localparam int unsigned AngleW = 16;
    localparam int unsigned PosW   = 32;
    localparam int unsigned EntryW = 24;

    // cordic datapath: 30 fraction bits plus sign and growth
    localparam int unsigned CordW  = 33;
    // angle accumulator in units of 2^-32 turn, residual below a quarter turn
    localparam int unsigned PhaseW = 32;
    localparam int unsigned TrigW  = 18;

    localparam logic signed [CordW-1:0] InitGain = 33'sd652032874;
    localparam logic signed [TrigW-1:0] TrigOne  = 18'sd65536;

    localparam logic signed [EntryW-1:0] EntryMax = 24'sh7FFFFF;
    localparam logic signed [EntryW-1:0] EntryMin = 24'sh800000;

    localparam int unsigned InW  = 3 * ScaleW + 3 * AngleW + 3 * PosW;
    localparam int unsigned OutW = 9 * EntryW + 3 * PosW;

    function automatic logic [PhaseW-1:0] atan_turn(input int unsigned idx);
        logic [PhaseW-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [CordW-1:0]  x;
        logic signed [CordW-1:0]  y;
        logic signed [PhaseW:0]   z;
    } t_rot;

    typedef struct packed {
        logic signed [TrigW-1:0] c;
        logic signed [TrigW-1:0] s;
    } t_trig;

endpackage
`default_nettype wire

@@ hw/rtl/mmtrs_cordic_cell.sv @@
`default_nettype none
// one cordic micro-rotation for three angles, plus delayed sideband
module mmtrs_cordic_cell #(
    parameter int unsigned STAGE = 0,
    parameter int unsigned SIDE_W = 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire mmtrs_pkg::t_rot [2:0]  i_rot,
    input  wire logic [SIDE_W-1:0]      i_side,
    output logic                        o_valid,
    output mmtrs_pkg::t_rot [2:0]       o_rot,
    output logic [SIDE_W-1:0]           o_side
);
    localparam logic signed [mmtrs_pkg::PhaseW:0] Atan =
        $signed({1'b0, mmtrs_pkg::atan_turn(STAGE)});

    mmtrs_pkg::t_rot [2:0] n_rot;
    mmtrs_pkg::t_rot [2:0] r_rot;
    logic [SIDE_W-1:0]     r_side;
    logic                  r_valid;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_rot[k].z[mmtrs_pkg::PhaseW]) begin
                n_rot[k].x = i_rot[k].x - (i_rot[k].y >>> STAGE);
                n_rot[k].y = i_rot[k].y + (i_rot[k].x >>> STAGE);
                n_rot[k].z = i_rot[k].z - Atan;
            end else begin
                n_rot[k].x = i_rot[k].x + (i_rot[k].y >>> STAGE);
                n_rot[k].y = i_rot[k].y - (i_rot[k].x >>> STAGE);
                n_rot[k].z = i_rot[k].z + Atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rot  <= n_rot;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_rot   = r_rot;
    assign o_side  = r_side;
endmodule
`default_nettype wire

@@ hw/rtl/mmtrs_matrix.sv @@
`default_nettype none
// trig folding, rotation entries and scaling; five register stages
module mmtrs_matrix (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_valid,
    input  wire mmtrs_pkg::t_rot [2:0]            i_rot,
    input  wire logic [5:0]                       i_quad,
    input  wire logic [3*mmtrs_pkg::ScaleW-1:0]   i_scale,
    input  wire logic [3*mmtrs_pkg::PosW-1:0]     i_pos,
    output logic                                  o_valid,
    output logic [mmtrs_pkg::OutW-1:0]            o_data
);
    localparam int unsigned TW = mmtrs_pkg::TrigW;
    localparam int unsigned SW = mmtrs_pkg::ScaleW;
    localparam int unsigned PW = mmtrs_pkg::PosW;
    localparam int unsigned EW = mmtrs_pkg::EntryW;
    localparam int unsigned SideW = 3 * SW + 3 * PW;

    logic [4:0] r_v;
    logic [SideW-1:0] r_side [5];

    function automatic logic signed [EW-1:0] sat(input logic signed [TW-1:0] r,
                                                 input logic signed [SW-1:0] s);
        logic signed [TW+SW-1:0] p;
        logic signed [TW+SW-1:0] q;
        p = r * s;
        q = (p + (TW+SW)'(32768)) >>> 16;
        if (q > (TW+SW)'(mmtrs_pkg::EntryMax)) return mmtrs_pkg::EntryMax;
        if (q < (TW+SW)'(mmtrs_pkg::EntryMin)) return mmtrs_pkg::EntryMin;
        return EW'(q);
    endfunction

    function automatic logic signed [SW-1:0] i_scale_d(input int unsigned k);
        return $signed(r_side[3][k*SW +: SW]);
    endfunction

    // stage 1: round, clamp and fold
    mmtrs_pkg::t_trig [2:0] n_trig, r_trig;
    always_comb begin
        logic signed [mmtrs_pkg::CordW-1:0] xr, yr;
        logic signed [TW-1:0] cr, sr;
        for (int k = 0; k < 3; k++) begin
            xr = (i_rot[k].x + 33'sd8192) >>> 14;
            yr = (i_rot[k].y + 33'sd8192) >>> 14;
            cr = (xr > 33'sd65536) ? mmtrs_pkg::TrigOne :
                 (xr < -33'sd65536) ? -mmtrs_pkg::TrigOne : TW'(xr);
            sr = (yr > 33'sd65536) ? mmtrs_pkg::TrigOne :
                 (yr < -33'sd65536) ? -mmtrs_pkg::TrigOne : TW'(yr);
            case (i_quad[2*k +: 2])
                2'd0: begin n_trig[k].c = cr;  n_trig[k].s = sr;  end
                2'd1: begin n_trig[k].c = -sr; n_trig[k].s = cr;  end
                2'd2: begin n_trig[k].c = -cr; n_trig[k].s = -sr; end
                default: begin n_trig[k].c = sr; n_trig[k].s = -cr; end
            endcase
        end
    end

    // stage 2: pairwise products, q.32
    logic signed [35:0] r_czcy, r_szcy, r_czsy, r_szsy, r_szcx, r_szsx,
                        r_czcx, r_czsx, r_cysx, r_cycx;
    logic signed [TW-1:0] r2_cx, r2_sx, r2_sy;
    // stage 3: triple products, q.48
    logic signed [55:0] r_e [9];
    // stage 4: rounded r16
    logic signed [TW-1:0] r_r16 [9];
    // stage 5: scaled entries
    logic signed [EW-1:0] r_m [9];

    logic signed [SW-1:0] sc [3];
    assign sc[0] = i_scale_d(0);
    assign sc[1] = i_scale_d(1);
    assign sc[2] = i_scale_d(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
        if (i_en) begin
            r_side[0] <= {i_pos, i_scale};
            for (int k = 1; k < 5; k++) r_side[k] <= r_side[k-1];
            r_trig <= n_trig;
            r_czcy <= r_trig[2].c * r_trig[1].c;
            r_szcy <= r_trig[2].s * r_trig[1].c;
            r_czsy <= r_trig[2].c * r_trig[1].s;
            r_szsy <= r_trig[2].s * r_trig[1].s;
            r_szcx <= r_trig[2].s * r_trig[0].c;
            r_szsx <= r_trig[2].s * r_trig[0].s;
            r_czcx <= r_trig[2].c * r_trig[0].c;
            r_czsx <= r_trig[2].c * r_trig[0].s;
            r_cysx <= r_trig[1].c * r_trig[0].s;
            r_cycx <= r_trig[1].c * r_trig[0].c;
            r2_cx  <= r_trig[0].c;
            r2_sx  <= r_trig[0].s;
            r2_sy  <= r_trig[1].s;
            r_e[0] <= 56'(r_czcy) <<< 16;
            r_e[1] <= r_czsy * r2_sx - (56'(r_szcx) <<< 16);
            r_e[2] <= r_czsy * r2_cx + (56'(r_szsx) <<< 16);
            r_e[3] <= 56'(r_szcy) <<< 16;
            r_e[4] <= r_szsy * r2_sx + (56'(r_czcx) <<< 16);
            r_e[5] <= r_szsy * r2_cx - (56'(r_czsx) <<< 16);
            r_e[6] <= -(56'(r2_sy) <<< 32);
            r_e[7] <= 56'(r_cysx) <<< 16;
            r_e[8] <= 56'(r_cycx) <<< 16;
            for (int k = 0; k < 9; k++)
                r_r16[k] <= TW'((r_e[k] + 56'sh80000000) >>> 32);
            for (int k = 0; k < 9; k++)
                r_m[k] <= sat(r_r16[k], sc[k%3]);
        end
    end

    // entries m00..m22 in the low bits, positions x, y, z above them
    logic [3*PW-1:0] pos;
    assign pos = r_side[4][SideW-1 -: 3*PW];
    assign o_valid = r_v[4];
    assign o_data = {pos, r_m[8], r_m[7], r_m[6], r_m[5], r_m[4],
                     r_m[3], r_m[2], r_m[1], r_m[0]};
endmodule
`default_nettype wire

@@ hw/rtl/model_matrix_from_trs_top.sv @@
// channel | dir | tdata fields, lowest bit first
// s_axis  | in  | scale_x scale_y scale_z angle_x angle_y angle_z pos_x pos_y pos_z (216 b)
// m_axis  | out | m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23 (312 b)
// one request per cycle while m_axis is not stalled
// a chain of cordic cells, one micro-rotation each, then five matrix stages
// stall on m_axis_tready freezes the whole chain; the output register holds
// reset clears only valid flags
`default_nettype none
module model_matrix_from_trs_top #(
    parameter int unsigned CORDIC_ITERATIONS = mmtrs_pkg::CordicIterDefault
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
    input  wire logic [mmtrs_pkg::InW-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // m00 m01 m02 m03 m10 m11 m12 m13 m20 m21 m22 m23
    output logic [mmtrs_pkg::OutW-1:0]        m_axis_tdata
);
    localparam int unsigned N = (CORDIC_ITERATIONS > mmtrs_pkg::CordicIterMax) ?
                                mmtrs_pkg::CordicIterMax : CORDIC_ITERATIONS;
    localparam int unsigned SW = mmtrs_pkg::ScaleW;
    localparam int unsigned AW = mmtrs_pkg::AngleW;
    localparam int unsigned SideW = 3 * SW + 3 * mmtrs_pkg::PosW + 6;

    // chain advances when the output slot is free or being taken
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    mmtrs_pkg::t_rot [2:0] rot [N+1];
    logic [SideW-1:0]      side [N+1];
    logic [N:0]            vld;

    logic [5:0] quad;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rot[0][k].x = mmtrs_pkg::InitGain;
            rot[0][k].y = '0;
            // residual below a quarter turn, in units of 2^-32 turn
            rot[0][k].z = {3'b000, s_axis_tdata[3*SW + k*AW +: 14], 16'd0};
            quad[2*k +: 2] = s_axis_tdata[3*SW + k*AW + 14 +: 2];
        end
    end
    assign side[0] = {s_axis_tdata[3*SW + 3*AW +: 3*mmtrs_pkg::PosW],
                      s_axis_tdata[0 +: 3*SW], quad};
    assign vld[0] = s_axis_tvalid;

    for (genvar g = 0; g < N; g++) begin : g_cell
        mmtrs_cordic_cell #(.STAGE(g), .SIDE_W(SideW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(vld[g]), .i_rot(rot[g]), .i_side(side[g]),
            .o_valid(vld[g+1]), .o_rot(rot[g+1]), .o_side(side[g+1])
        );
    end

    logic mv;
    logic [mmtrs_pkg::OutW-1:0] md;
    mmtrs_matrix u_matrix (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(vld[N]),
        .i_rot(rot[N]), .i_quad(side[N][5:0]),
        .i_scale(side[N][6 +: 3*SW]),
        .i_pos(side[N][6 + 3*SW +: 3*mmtrs_pkg::PosW]),
        .o_valid(mv), .o_data(md)
    );

    // output register: m00..m02 then m03 etc. repacked in field order
    logic [8:0][23:0] me;
    logic [2:0][31:0] mp;
    assign me = md[0 +: 216];
    assign mp = md[216 +: 96];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (en) begin
            m_axis_tvalid <= mv;
        end
        if (en) begin
            m_axis_tdata <= {mp[2], me[8], me[7], me[6],
                             mp[1], me[5], me[4], me[3],
                             mp[0], me[2], me[1], me[0]};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/mmtrs_checker.sv @@
`default_nettype none
module mmtrs_props (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [311:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("not ready while output drains");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("accepting while stalled");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind model_matrix_from_trs_top mmtrs_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ tb/sv/mmtrs_checker.sv @@
`default_nettype none
module mmtrs_checker #(
    parameter int unsigned CORDIC_ITERATIONS = mmtrs_pkg::CordicIterDefault
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_req_valid,
    input  wire logic                      i_req_ready,
    input  wire logic [mmtrs_pkg::InW-1:0] i_req_data,
    input  wire logic                      i_mat_valid,
    input  wire logic                      i_mat_ready,
    input  wire logic [mmtrs_pkg::OutW-1:0] i_mat_data,
    output int                             o_errors,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RowW = 3 * mmtrs_pkg::EntryW + mmtrs_pkg::PosW;

    logic [mmtrs_pkg::OutW-1:0] matrix_q[$];
    string entry_name[12] = '{"m00", "m01", "m02", "m03", "m10", "m11", "m12", "m13",
                              "m20", "m21", "m22", "m23"};

    // arc tangent of 2^-i in units of 2^-32 turn
    longint arc_turn[24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

    function automatic longint round_sh(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_one(input longint v);
        if (v > 65536) return 65536;
        if (v < -65536) return -65536;
        return v;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        longint x, y, z, dx, dy, cr, sr;
        x = 652032874;
        y = 0;
        z = longint'({ang[13:0], 16'b0});
        for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arc_turn[i];
            end else begin
                x += dx; y -= dy; z += arc_turn[i];
            end
        end
        cr = clamp_one(round_sh(x, 14));
        sr = clamp_one(round_sh(y, 14));
        case (ang[15:14])
            2'd0: begin c = cr;  s = sr;  end
            2'd1: begin c = -sr; s = cr;  end
            2'd2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    // rotation term with 48 fraction bits times a Q8.16 scale, saturated
    function automatic logic [23:0] scaled_entry(input longint r48, input longint scl);
        longint v;
        v = round_sh(round_sh(r48, 32) * scl, 16);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic logic [mmtrs_pkg::OutW-1:0] model_matrix(
        input logic [mmtrs_pkg::InW-1:0] d);
        longint sx_, sy_, sz_, cx, snx, cy, sny, cz, snz, czsy, szsy, k16, k32;
        logic [mmtrs_pkg::OutW-1:0] m;
        sx_ = longint'($signed(d[23:0]));
        sy_ = longint'($signed(d[47:24]));
        sz_ = longint'($signed(d[71:48]));
        sin_cos(d[87:72], cx, snx);
        sin_cos(d[103:88], cy, sny);
        sin_cos(d[119:104], cz, snz);
        k16 = 65536;
        k32 = 64'sd1 <<< 32;
        czsy = cz * sny;
        szsy = snz * sny;
        m = '0;
        m[0   +: 24] = scaled_entry(cz * cy * k16, sx_);
        m[24  +: 24] = scaled_entry(czsy * snx - snz * cx * k16, sy_);
        m[48  +: 24] = scaled_entry(czsy * cx + snz * snx * k16, sz_);
        m[72  +: 32] = d[151:120];
        m[104 +: 24] = scaled_entry(snz * cy * k16, sx_);
        m[128 +: 24] = scaled_entry(szsy * snx + cz * cx * k16, sy_);
        m[152 +: 24] = scaled_entry(szsy * cx - cz * snx * k16, sz_);
        m[176 +: 32] = d[183:152];
        m[208 +: 24] = scaled_entry(-sny * k32, sx_);
        m[232 +: 24] = scaled_entry(cy * snx * k16, sy_);
        m[256 +: 24] = scaled_entry(cy * cx * k16, sz_);
        m[280 +: 32] = d[215:184];
        return m;
    endfunction

    initial o_errors = 0;
    assign o_pending = matrix_q.size();

    always @(posedge i_clk) begin
        logic [mmtrs_pkg::OutW-1:0] exp_m;
        int off, w, n_bad;
        logic [31:0] e_f, a_f;
        n_bad = 0;
        if (i_rst_n && i_req_valid && i_req_ready)
            matrix_q.push_back(model_matrix(i_req_data));
        if (i_rst_n && i_mat_valid && i_mat_ready) begin
            if (matrix_q.size() == 0) begin
                $error("unexpected matrix %h", i_mat_data);
                n_bad++;
            end else begin
                exp_m = matrix_q.pop_front();
                for (int j = 0; j < 12; j++) begin
                    off = (j / 4) * RowW + (j % 4) * 24;
                    w = (j % 4 == 3) ? 32 : 24;
                    e_f = 32'(exp_m[off +: 32] & ((64'd1 << w) - 1));
                    a_f = 32'(i_mat_data[off +: 32] & ((64'd1 << w) - 1));
                    if (e_f !== a_f) begin
                        $error("%s expected %h actual %h", entry_name[j], e_f, a_f);
                        n_bad++;
                    end
                end
            end
        end
        if (n_bad != 0)
            o_errors <= o_errors + n_bad;
    end
endmodule
`default_nettype wire

@@ tb/sv/tb_model_matrix_from_trs_top.sv @@
`default_nettype none
module tb_model_matrix_from_trs_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumRandom = 880;
    localparam int CycleLimit = 300000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [mmtrs_pkg::InW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [mmtrs_pkg::OutW-1:0] m_axis_tdata;
    int errors, pending;
    int n_sent = 0;
    int n_recv = 0;
    longint cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    model_matrix_from_trs_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    mmtrs_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_mat_valid(m_axis_tvalid), .i_mat_ready(m_axis_tready),
        .i_mat_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    // wait per item, with stretches of back-to-back traffic
    function automatic int idle_cycles(input int n);
        if ((n % 300) >= 120 && (n % 300) < 200) return 0;
        return $urandom_range(0, 11);
    endfunction

    // fields packed lowest first: scales, angles, positions
    function automatic logic [mmtrs_pkg::InW-1:0] pack_request(
        input logic [23:0] scx, input logic [23:0] scy, input logic [23:0] scz,
        input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
        input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz);
        return {pz, py, px, az, ay, ax, scz, scy, scx};
    endfunction

    task automatic send_request(input logic [mmtrs_pkg::InW-1:0] d);
        int gap;
        gap = idle_cycles(n_sent);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
    endtask

    function automatic logic [23:0] rand_scale();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h010000;
            3: return 24'hFF0000;
            4: return 24'($signed($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 7))
            0: return 16'($urandom_range(0, 3)) << 14;
            1: return (16'($urandom_range(0, 3)) << 14) - 16'd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [23:0] corner_scale[4];
        logic [15:0] corner_angle[8];
        corner_scale = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h010000};
        corner_angle = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h3FFF,
                         16'h2000, 16'h7FFF};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes of scale and each quadrant boundary of the angles
        for (int k = 0; k < 8; k++)
            send_request(pack_request(corner_scale[k % 4], corner_scale[(k + 1) % 4],
                corner_scale[(k + 2) % 4], corner_angle[k], corner_angle[(k + 3) % 8],
                corner_angle[(k + 5) % 8], 32'h7FFFFFFF, 32'h80000000, 32'h0));
        // half turn against most negative scale drives the diagonal toward the low limit
        send_request(pack_request(24'h800000, 24'h800000, 24'h800000, 16'h8000,
            16'h8000, 16'h8000, 32'hFFFFFFFF, 32'h0, 32'h12345678));
        send_request(pack_request(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hC000,
            16'h4000, 16'hFFFF, 32'h0, 32'hFFFFFFFF, 32'h80000000));
        for (int k = 0; k < 8; k++)
            send_request(pack_request(24'h010000, 24'hFF0000, 24'h800000,
                corner_angle[k], corner_angle[k], corner_angle[7 - k],
                $urandom, $urandom, $urandom));
        for (int k = 0; k < NumRandom; k++)
            send_request(pack_request(rand_scale(), rand_scale(), rand_scale(),
                rand_angle(), rand_angle(), rand_angle(), $urandom, $urandom, $urandom));
        s_axis_tvalid <= 1'b0;
        // drain, then let the pipeline settle
        wait (n_recv == n_sent && pending == 0);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("tb_model_matrix_from_trs_top passed");
        else
            $display("tb_model_matrix_from_trs_top failed");
        $finish;
    end

    // result side: random stalls plus one long hold-off to back up the pipeline
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_recv == 60) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else begin
                gap = idle_cycles(n_recv + 50);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
            n_recv++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb_model_matrix_from_trs_top failed");
            $finish;
        end
    end
endmodule
`default_nettype wire
